// ----- hw/rtl/vgr_pkg.sv -----
// Package for the vertical gradient raster block.
// Holds sizes, register indexes, the sequencer state type and the size clamp.
// No dependencies.
package vgr_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);  // holds 0..MAX_DIM
  localparam int POS_W     = 12;                   // pixel_row / pixel_col width
  localparam int COLOR_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CHAN_W    = 8;
  localparam int NUM_W     = CHAN_W + DIM_W - 1;   // channel * MAX_DIM fits here
  localparam logic [CHAN_W-1:0] ALPHA = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_COLOR    = 2'd0,
    REG_BOTTOM_COLOR = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_TOP,
    ST_MUL_BOT,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // zero reads as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/vgr_in_if.sv -----
// Input stream interface of the gradient raster: valid/ready plus restart flag.
// No dependencies.
interface vgr_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ----- hw/rtl/vgr_out_if.sv -----
// Pixel stream interface of the gradient raster: valid/ready plus pixel payload.
// No dependencies.
interface vgr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_color;
  logic [11:0] pixel_row;
  logic [11:0] pixel_col;
  logic        frame_last;

  modport source (output valid, output pixel_color, output pixel_row,
                  output pixel_col, output frame_last, input ready);
  modport sink   (input valid, input pixel_color, input pixel_row,
                  input pixel_col, input frame_last, output ready);
endinterface

// ----- hw/rtl/vertical_gradient_raster.sv -----
// Vertical gradient raster: emits one ARGB pixel per input transaction.
// Depends on vgr_pkg, vgr_in_if and vgr_out_if.
//
// Usage:
//   in_stream  : one transaction per wanted pixel; restart=1 returns to row 0,
//                column 0 before that pixel is produced.
//   out_stream : one pixel per input transaction, in raster order, with its
//                row, column and a frame_last flag on the final pixel.
//   cfg_*      : write enable, register index and data; top color, bottom
//                color, frame width, frame height. Write only while idle.
// Each channel is floor((top*(h-r) + bottom*r) / h), alpha is 0xFF.
// Sequence: per channel one multiply step for the top term, one for the bottom
// term plus sum, then 8 restoring-divide steps, all on one shared
// multiplier/subtractor. After the three channels a load step fills the
// output register once it is free, and the sequencer then returns to idle;
// only in idle is a new transaction taken.
// The output register decouples the sides: the next transaction is accepted
// and computed while a pixel waits; if the receiver still stalls when that
// next pixel is done, the sequencer holds it until the register frees up.
// Reset clears the position to row 0, column 0 and loads the default
// registers (black to white, 640 by 360).
module vertical_gradient_raster (
  input  logic                           clk,
  input  logic                           rst_n,
  vgr_in_if.sink                         in_stream,
  vgr_out_if.source                      out_stream,
  input  logic                           cfg_we,
  input  logic [vgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vgr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vgr_pkg::*;

  // configuration
  logic [COLOR_W-1:0] top_color_r, bottom_color_r;
  logic [DIM_W-1:0]   frame_width_r, frame_height_r;
  logic [DIM_W-1:0]   w_eff, h_eff;

  // position and sequencer
  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   row_cnt_r, col_cnt_r;
  logic [POS_W-1:0]   pix_row_r, pix_col_r;
  logic               pix_last_r;
  logic [DIM_W-1:0]   h_r;
  logic [1:0]         ch_r;
  logic [2:0]         div_cnt_r;

  // shared arithmetic
  logic [NUM_W-1:0]   acc_r;
  logic [DIM_W-1:0]   rem_r;
  logic [CHAN_W-1:0]  low_r, quo_r;
  logic [COLOR_W-1:0] color_r;

  // output register
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [POS_W-1:0]   out_row_r, out_col_r;
  logic               out_last_r;

  logic               accept, out_take, out_free, load_out;
  logic               div_last, ch_last;

  assign w_eff = clamp_dim(frame_width_r);
  assign h_eff = clamp_dim(frame_height_r);

  // ---------------- configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_color_r    <= '0;
      bottom_color_r <= '1;
      frame_width_r  <= DIM_W'(640);
      frame_height_r <= DIM_W'(360);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOP_COLOR:    top_color_r    <= cfg_data[COLOR_W-1:0];
        REG_BOTTOM_COLOR: bottom_color_r <= cfg_data[COLOR_W-1:0];
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- position of the accepted pixel and of the next one
  logic [DIM_W-1:0] c0, r0, c1, r1, r2, cn, rn;
  logic             pos_last;

  always_comb begin
    c0 = in_stream.restart ? '0 : {1'b0, col_cnt_r};
    r0 = in_stream.restart ? '0 : {1'b0, row_cnt_r};
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + DIM_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h_eff) ? '0 : r1;
    pos_last = (r2 == h_eff - DIM_W'(1)) && (c1 == w_eff - DIM_W'(1));
    cn = c1 + DIM_W'(1);
    rn = r2;
    if (cn >= w_eff) begin
      cn = '0;
      rn = r2 + DIM_W'(1);
      if (rn >= h_eff) begin
        rn = '0;
      end
    end
  end

  // ---------------- sequencer: next state
  assign div_last = (div_cnt_r == 3'd7);
  assign ch_last  = (ch_r == CH_BLUE);
  assign out_take = out_valid_r && out_stream.ready;
  assign out_free = !out_valid_r || out_stream.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_MUL_TOP;
      ST_MUL_TOP: state_nxt = ST_MUL_BOT;
      ST_MUL_BOT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_last) state_nxt = ch_last ? ST_LOAD : ST_MUL_TOP;
      end
      ST_LOAD:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs
  always_comb begin
    in_stream.ready = (state_r == ST_IDLE);
    load_out        = (state_r == ST_LOAD) && out_free;
  end
  assign accept = in_stream.valid && in_stream.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      ch_r      <= CH_RED;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        row_cnt_r <= rn[POS_W-1:0];
        col_cnt_r <= cn[POS_W-1:0];
        ch_r      <= CH_RED;
      end
      if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + 3'd1;
        if (div_last) ch_r <= ch_r + 2'd1;
      end
    end
  end

  // ---------------- shared multiply / divide unit
  logic [CHAN_W-1:0]         top_ch, bot_ch, mul_a;
  logic [DIM_W-1:0]          mul_b;
  logic [CHAN_W+DIM_W-1:0]   prod;
  logic [NUM_W-1:0]          num_sum;
  logic [DIM_W:0]            trial;
  logic                      ge;

  always_comb begin
    case (chan_t'(ch_r))
      CH_RED:   begin top_ch = top_color_r[23:16]; bot_ch = bottom_color_r[23:16]; end
      CH_GREEN: begin top_ch = top_color_r[15:8];  bot_ch = bottom_color_r[15:8];  end
      CH_BLUE:  begin top_ch = top_color_r[7:0];   bot_ch = bottom_color_r[7:0];   end
      default:  begin top_ch = top_color_r[7:0];   bot_ch = bottom_color_r[7:0];   end
    endcase
    if (state_r == ST_MUL_TOP) begin
      mul_a = top_ch;
      mul_b = h_r - {1'b0, pix_row_r};
    end else begin
      mul_a = bot_ch;
      mul_b = {1'b0, pix_row_r};
    end
    prod    = (CHAN_W+DIM_W)'(mul_a) * (CHAN_W+DIM_W)'(mul_b);
    num_sum = acc_r + prod[NUM_W-1:0];
    trial   = {rem_r, low_r[CHAN_W-1]};
    ge      = (trial >= {1'b0, h_r});
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_row_r  <= r2[POS_W-1:0];
      pix_col_r  <= c1[POS_W-1:0];
      pix_last_r <= pos_last;
      h_r        <= h_eff;
    end
    case (state_r)
      ST_MUL_TOP: acc_r <= prod[NUM_W-1:0];
      ST_MUL_BOT: begin
        // quotient fits 8 bits, so the high part is already below h
        rem_r <= DIM_W'(num_sum[NUM_W-1:CHAN_W]);
        low_r <= num_sum[CHAN_W-1:0];
      end
      ST_DIV: begin
        rem_r <= ge ? DIM_W'(trial - {1'b0, h_r}) : DIM_W'(trial);
        low_r <= {low_r[CHAN_W-2:0], 1'b0};
        quo_r <= {quo_r[CHAN_W-2:0], ge};
        if (div_last) begin
          case (chan_t'(ch_r))
            CH_RED:   color_r[23:16] <= {quo_r[CHAN_W-2:0], ge};
            CH_GREEN: color_r[15:8]  <= {quo_r[CHAN_W-2:0], ge};
            CH_BLUE:  color_r[7:0]   <= {quo_r[CHAN_W-2:0], ge};
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_color_r <= color_r;
      out_row_r   <= pix_row_r;
      out_col_r   <= pix_col_r;
      out_last_r  <= pix_last_r;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.pixel_color = {ALPHA, out_color_r};
  assign out_stream.pixel_row   = out_row_r;
  assign out_stream.pixel_col   = out_col_r;
  assign out_stream.frame_last  = out_last_r;

  // ---------------- assertions
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_MUL_TOP) && (ch_r == CH_RED))
    else $error("accepted transaction did not start on red channel");

  a_div_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DIV) |-> (div_cnt_r == 3'd0))
    else $error("divide step counter left nonzero outside divide");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < h_r))
    else $error("divider remainder not below divisor");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == ST_IDLE))
    else $error("loaded pixel not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) && out_valid_r && !out_stream.ready |=> (state_r == ST_LOAD))
    else $error("sequencer left load while output register was full");

endmodule
